### rtl/core/drdf_pkg.sv
package drdf_pkg;

  localparam int PAYLOAD_BYTES_DEF = 64;
  localparam int CFG_ADDR_W        = 5;
  localparam int CFG_DATA_W        = 32;
  localparam int OUT_TDATA_W       = 32;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_UID,
    PH_FLAG,
    PH_SNAME,
    PH_NAME,
    PH_TAIL,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_UID   = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_FRAME = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_START_FRAME = 3'd0,
    REG_END_FRAME   = 3'd1,
    REG_START_NAME  = 3'd2,
    REG_END_NAME    = 3'd3,
    REG_TRUE        = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] start_frame_code;
    logic [7:0] end_frame_code;
    logic [7:0] start_name_code;
    logic [7:0] end_name_code;
    logic [7:0] true_code;
  } codes_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [5:0] position;
    logic       user_identified;
    logic [7:0] uid_length;
    status_t    frame_status;
  } result_t;

endpackage

### rtl/core/drdf_parser.sv
module drdf_parser #(
  parameter int PAYLOAD_BYTES = drdf_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  drdf_pkg::codes_t codes,
  output logic             res_valid,
  output drdf_pkg::result_t res
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

  drdf_pkg::phase_t  phase_r, phase_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        uid_exp_r, uid_exp_nxt;
  logic [7:0]        idx_r, idx_nxt;
  logic              ident_r, ident_nxt;
  drdf_pkg::status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= drdf_pkg::PH_IDLE;
      count_r   <= '0;
      uid_exp_r <= '0;
      idx_r     <= '0;
      ident_r   <= 1'b0;
      status_r  <= drdf_pkg::ST_OK;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      uid_exp_r <= uid_exp_nxt;
      idx_r     <= idx_nxt;
      ident_r   <= ident_nxt;
      status_r  <= status_nxt;
    end
  end

  always_comb begin
    phase_nxt           = phase_r;
    count_nxt           = count_r;
    uid_exp_nxt         = uid_exp_r;
    idx_nxt             = idx_r;
    ident_nxt           = ident_r;
    status_nxt          = status_r;
    res_valid           = 1'b0;
    res.kind            = drdf_pkg::KIND_UID;
    res.data_byte       = '0;
    res.position        = '0;
    res.user_identified = 1'b0;
    res.uid_length      = '0;
    res.frame_status    = drdf_pkg::ST_OK;
    if (step) begin
      if (phase_r == drdf_pkg::PH_IDLE) begin
        if (rx_byte == codes.start_frame_code) begin
          phase_nxt   = drdf_pkg::PH_LEN;
          count_nxt   = '0;
          uid_exp_nxt = '0;
          idx_nxt     = '0;
          ident_nxt   = 1'b0;
          status_nxt  = drdf_pkg::ST_TRUNC;
        end
      end else if (rx_byte == codes.end_frame_code) begin
        res_valid           = 1'b1;
        res.kind            = drdf_pkg::KIND_FRAME;
        res.user_identified = ident_r;
        res.uid_length      = uid_exp_r;
        res.frame_status    = status_r;
        phase_nxt           = drdf_pkg::PH_IDLE;
        count_nxt           = '0;
        idx_nxt             = '0;
      end else if (phase_r == drdf_pkg::PH_DISCARD) begin
        phase_nxt = drdf_pkg::PH_DISCARD;
      end else if (count_r >= CNT_W'(PAYLOAD_BYTES)) begin
        status_nxt = drdf_pkg::ST_OVER;
        phase_nxt  = drdf_pkg::PH_DISCARD;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        case (phase_r)
          drdf_pkg::PH_LEN: begin
            uid_exp_nxt = rx_byte;
            idx_nxt     = '0;
            phase_nxt   = (rx_byte == 8'd0) ? drdf_pkg::PH_FLAG : drdf_pkg::PH_UID;
          end
          drdf_pkg::PH_UID: begin
            res_valid     = 1'b1;
            res.kind      = drdf_pkg::KIND_UID;
            res.data_byte = rx_byte;
            res.position  = idx_r[5:0];
            idx_nxt       = idx_r + 8'd1;
            if (idx_r + 8'd1 == uid_exp_r) begin
              phase_nxt = drdf_pkg::PH_FLAG;
            end
          end
          drdf_pkg::PH_FLAG: begin
            ident_nxt = (rx_byte == codes.true_code);
            phase_nxt = drdf_pkg::PH_SNAME;
          end
          drdf_pkg::PH_SNAME: begin
            idx_nxt   = '0;
            phase_nxt = (rx_byte == codes.start_name_code) ? drdf_pkg::PH_NAME
                                                           : drdf_pkg::PH_DISCARD;
          end
          drdf_pkg::PH_NAME: begin
            if (rx_byte == codes.end_name_code) begin
              status_nxt = drdf_pkg::ST_OK;
              phase_nxt  = drdf_pkg::PH_TAIL;
            end else begin
              res_valid     = 1'b1;
              res.kind      = drdf_pkg::KIND_NAME;
              res.data_byte = rx_byte;
              res.position  = idx_r[5:0];
              idx_nxt       = idx_r + 8'd1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

endmodule

### rtl/core/delimited_record_deframer_unit.sv
// Channel  Direction  Payload
// in_      slave      rx_byte
// out_     master     tuser: kind; tdata: data_byte, position, user_identified,
//                     uid_length, frame_status
// cfg_     APB        five 8-bit code registers at 4*i
//
// One byte is taken per cycle unless the output stalls; byte and result are registered.
// Rate is set by the input register and the result register around the parser.
// Synchronous active-low reset returns the parser to idle and codes to defaults.
// A stalled output holds the result; the input register then holds one byte.
module delimited_record_deframer_unit #(
  parameter int PAYLOAD_BYTES = drdf_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [drdf_pkg::OUT_TDATA_W-1:0] out_tdata, // [7:0] data_byte, [13:8] position,
                                                      // [14] user_identified,
                                                      // [22:15] uid_length,
                                                      // [24:23] frame_status
  output logic [1:0]                      out_tuser,  // [1:0] kind
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [drdf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [drdf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [drdf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  drdf_pkg::codes_t  codes_r;
  drdf_pkg::reg_idx_t reg_idx;
  logic [7:0]        rd_byte;
  logic              cfg_wr;

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              step;
  logic              res_valid;
  drdf_pkg::result_t res;
  logic              out_valid_r;
  drdf_pkg::result_t out_res_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = drdf_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.start_frame_code <= 8'd1;
      codes_r.end_frame_code   <= 8'd4;
      codes_r.start_name_code  <= 8'd2;
      codes_r.end_name_code    <= 8'd3;
      codes_r.true_code        <= 8'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        drdf_pkg::REG_START_FRAME: codes_r.start_frame_code <= cfg_pwdata[7:0];
        drdf_pkg::REG_END_FRAME:   codes_r.end_frame_code   <= cfg_pwdata[7:0];
        drdf_pkg::REG_START_NAME:  codes_r.start_name_code  <= cfg_pwdata[7:0];
        drdf_pkg::REG_END_NAME:    codes_r.end_name_code    <= cfg_pwdata[7:0];
        drdf_pkg::REG_TRUE:        codes_r.true_code        <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      drdf_pkg::REG_START_FRAME: rd_byte = codes_r.start_frame_code;
      drdf_pkg::REG_END_FRAME:   rd_byte = codes_r.end_frame_code;
      drdf_pkg::REG_START_NAME:  rd_byte = codes_r.start_name_code;
      drdf_pkg::REG_END_NAME:    rd_byte = codes_r.end_name_code;
      drdf_pkg::REG_TRUE:        rd_byte = codes_r.true_code;
      default:                   rd_byte = 8'd0;
    endcase
  end

  assign cfg_prdata = {{(drdf_pkg::CFG_DATA_W-8){1'b0}}, rd_byte};

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  drdf_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .codes     (codes_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {{(drdf_pkg::OUT_TDATA_W-25){1'b0}},
                       out_res_r.frame_status,
                       out_res_r.uid_length,
                       out_res_r.user_identified,
                       out_res_r.position,
                       out_res_r.data_byte};

  a_frame_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == drdf_pkg::KIND_FRAME |-> out_tdata[13:0] == 14'd0)
    else $error("frame result carries data or position");

  a_byte_no_frame_info: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != drdf_pkg::KIND_FRAME |-> out_tdata[24:14] == 11'd0)
    else $error("byte result carries frame fields");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r && $stable(in_byte_r))
    else $error("stalled input byte lost");

  a_no_result_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_res_r))
    else $error("pending result overwritten");

endmodule
